@@ design/bsvi_pkg.sv @@
`timescale 1ns / 1ps

package bsvi_pkg;

  // Geometry of the lookup tables.
  localparam int NPTS   = 11;
  localparam int IDX_W  = 4;
  localparam int VAL_W  = 16;

  // Every segment of every table spans at most 1000 units in x and in y.
  localparam int DIFF_W = 10;
  localparam int NUM_W  = 2 * DIFF_W;
  localparam int QUO_W  = 10;

  localparam int QUEUE_DEPTH_DEF = 4;

  // Input action codes.
  localparam logic ACT_V2S = 1'b0;
  localparam logic ACT_S2V = 1'b1;

  // Result region codes.
  localparam logic [1:0] REGION_INTERP = 2'd0;
  localparam logic [1:0] REGION_TOP    = 2'd1;
  localparam logic [1:0] REGION_BOTTOM = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_PACK = 1'b0;
  localparam logic CFG_GAIN = 1'b1;

  localparam logic [1:0]       PACK_RESET = 2'd0;
  localparam logic [VAL_W-1:0] GAIN_RESET = 16'd32768;

  // Charge returned for a voltage at or below the bottom point.
  localparam logic [VAL_W-1:0] SOC_FLOOR = 16'd500;

  // Pack voltage points in 10 mV units, highest first, one row per pack type.
  localparam logic [0:3][0:NPTS-1][VAL_W-1:0] VOLT_TAB = '{
    '{16'd1460, 16'd1400, 16'd1360, 16'd1340, 16'd1325, 16'd1320,
      16'd1300, 16'd1280, 16'd1260, 16'd1240, 16'd1200},
    '{16'd2920, 16'd2800, 16'd2720, 16'd2680, 16'd2650, 16'd2640,
      16'd2600, 16'd2560, 16'd2520, 16'd2480, 16'd2400},
    '{16'd4380, 16'd4200, 16'd4080, 16'd4020, 16'd3975, 16'd3960,
      16'd3900, 16'd3840, 16'd3780, 16'd3720, 16'd3600},
    '{16'd5840, 16'd5600, 16'd5440, 16'd5360, 16'd5300, 16'd5280,
      16'd5200, 16'd5120, 16'd5040, 16'd4960, 16'd4800}
  };

  // Charge points in 0.01 percent, matching the voltage columns.
  localparam logic [0:NPTS-1][VAL_W-1:0] SOC_TAB = '{
    16'd10000, 16'd9500, 16'd9000, 16'd8000, 16'd7000, 16'd6000,
    16'd5000,  16'd4000, 16'd3000, 16'd2000, 16'd1000
  };

  typedef struct packed {
    logic             action;
    logic [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [VAL_W-1:0] answer;
    logic [1:0]       region;
  } result_t;

  // One classified item: answer = base + dy * off / dx.
  typedef struct packed {
    logic [1:0]        region;
    logic [VAL_W-1:0]  base;
    logic [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0] off;
    logic [DIFF_W-1:0] dx;
  } job_t;

  typedef struct packed {
    logic full;
    logic almost_full;
    logic empty;
  } qstat_t;

endpackage

@@ design/bsvi_front.sv @@
`timescale 1ns / 1ps

module bsvi_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bsvi_pkg::request_t request,
  input  logic [1:0]        pack_type,
  input  logic [15:0]       sensor_gain,
  input  bsvi_pkg::qstat_t  qstat,
  output logic              push,
  output bsvi_pkg::job_t    job
);
  import bsvi_pkg::*;

  logic             s1_valid;
  logic             s1_action;
  logic [VAL_W-1:0] s1_value;
  logic [31:0]      s1_prod;

  logic             take;
  logic [16:0]      scaled;
  logic [VAL_W-1:0] x;
  logic [VAL_W-1:0] xp [NPTS];
  logic [VAL_W-1:0] yp [NPTS];
  logic [NPTS-2:0]  ge;
  logic [IDX_W-1:0] seg;
  logic [IDX_W-1:0] seg_lo;
  logic             found;
  logic [VAL_W-1:0] dy_full;
  logic [VAL_W-1:0] dx_full;
  logic [VAL_W-1:0] off_full;
  logic             at_bottom;

  // Room is needed for the item now in the classify stage and the new one.
  assign busy = qstat.full | (qstat.almost_full & s1_valid);
  assign take = start & ~busy;
  assign push = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_action <= request.action;
      s1_value  <= request.value;
      s1_prod   <= {16'd0, request.value} * {16'd0, sensor_gain};
    end
  end

  always_comb begin
    scaled = s1_prod[31:15];
    if (s1_action == ACT_S2V) begin
      x = s1_value;
    end else begin
      x = scaled[16] ? 16'hFFFF : scaled[15:0];
    end
    for (int i = 0; i < NPTS; i++) begin
      xp[i] = (s1_action == ACT_S2V) ? SOC_TAB[i] : VOLT_TAB[pack_type][i];
      yp[i] = (s1_action == ACT_S2V) ? VOLT_TAB[pack_type][i] : SOC_TAB[i];
    end
    for (int i = 0; i < NPTS - 1; i++) begin
      ge[i] = (x >= xp[i + 1]);
    end
    // The segment searched first from the top of the table wins.
    seg   = '0;
    found = 1'b0;
    for (int i = NPTS - 2; i >= 0; i--) begin
      if (ge[i]) begin
        seg   = IDX_W'(i);
        found = 1'b1;
      end
    end
    seg_lo   = seg + IDX_W'(1);
    dy_full  = yp[seg] - yp[seg_lo];
    dx_full  = xp[seg] - xp[seg_lo];
    off_full = x - xp[seg_lo];

    // A voltage equal to the bottom point clamps, a charge equal to it does not.
    if (s1_action == ACT_S2V) begin
      at_bottom = (x < xp[NPTS - 1]);
    end else begin
      at_bottom = (x <= xp[NPTS - 1]);
    end

    job.dy  = '0;
    job.off = '0;
    job.dx  = DIFF_W'(1);
    priority if (x >= xp[0]) begin
      job.region = REGION_TOP;
      job.base   = yp[0];
    end else if (at_bottom) begin
      job.region = REGION_BOTTOM;
      job.base   = (s1_action == ACT_S2V) ? yp[NPTS - 1] : SOC_FLOOR;
    end else if (found) begin
      job.region = REGION_INTERP;
      job.base   = yp[seg_lo];
      job.dy     = dy_full[DIFF_W-1:0];
      job.off    = off_full[DIFF_W-1:0];
      job.dx     = dx_full[DIFF_W-1:0];
    end else begin
      job.region = REGION_INTERP;
      job.base   = '0;
    end
  end

endmodule

@@ design/bsvi_queue.sv @@
`timescale 1ns / 1ps

module bsvi_queue #(
  parameter int DEPTH = bsvi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bsvi_pkg::job_t   push_data,
  input  logic             pop,
  output bsvi_pkg::job_t   pop_data,
  output bsvi_pkg::qstat_t qstat
);
  import bsvi_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign pop_data          = mem[rd_ptr];
  assign qstat.empty       = (count == '0);
  assign qstat.full        = (count == CW'(DEPTH));
  assign qstat.almost_full = (count >= CW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/bsvi_back.sv @@
`timescale 1ns / 1ps

module bsvi_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              avail,
  input  bsvi_pkg::job_t    job,
  output logic              pop,
  output logic              done,
  output bsvi_pkg::result_t result
);
  import bsvi_pkg::*;

  logic [QUO_W:0]    vld;
  logic [NUM_W-1:0]  rem    [QUO_W];
  logic [DIFF_W-1:0] dvs    [QUO_W];
  logic [QUO_W-1:0]  quo    [QUO_W+1];
  logic [VAL_W-1:0]  base   [QUO_W+1];
  logic [1:0]        region [QUO_W+1];

  // The back end never stalls, so it drains the queue whenever it holds work.
  assign pop = avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[QUO_W-1:0], avail};
    end
  end

  always_ff @(posedge clk) begin
    if (avail) begin
      rem[0]    <= {{(NUM_W-2*DIFF_W){1'b0}}, job.dy} * {{(NUM_W-2*DIFF_W){1'b0}}, job.off};
      dvs[0]    <= job.dx;
      quo[0]    <= '0;
      base[0]   <= job.base;
      region[0] <= job.region;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    localparam int B = QUO_W - 1 - k;
    localparam logic [QUO_W-1:0] QBIT = QUO_W'(1) << B;

    logic [NUM_W-1:0] trial;
    logic             fits;

    assign trial = {{(NUM_W-DIFF_W){1'b0}}, dvs[k]} << B;
    assign fits  = (rem[k] >= trial);

    always_ff @(posedge clk) begin
      quo[k+1]    <= fits ? (quo[k] | QBIT) : quo[k];
      base[k+1]   <= base[k];
      region[k+1] <= region[k];
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem[k+1] <= fits ? (rem[k] - trial) : rem[k];
        dvs[k+1] <= dvs[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    result.answer <= base[QUO_W] + {{(VAL_W-QUO_W){1'b0}}, quo[QUO_W]};
    result.region <= region[QUO_W];
  end

endmodule

@@ design/battery_soc_voltage_interpolator.sv @@
`timescale 1ns / 1ps

// Channel   Handshake              Payload               Direction
// request   start / busy           request (action, value) in
// result    done (one-cycle strobe) result (answer, region) out
// config    cfg_valid / cfg_ready  cfg_index, cfg_data    in
//
// A request transfers at a rising edge with start high and busy low; one item
// can transfer in every cycle. The sustained rate of one item per cycle is set
// by the queue draining one entry a cycle into a fully pipelined back end whose
// ten-stage restoring divider takes a new dividend every cycle. Each result
// appears on done in request order. Reset is synchronous and clears the
// configuration to pack type 0 and unity gain. The receiver cannot stall.
// Busy rises only when the queue cannot hold both the item in the classify
// stage and a new one; the back end drains a job every cycle, so at the
// default queue depth the queue never fills and busy stays low.
module battery_soc_voltage_interpolator #(
  parameter int QUEUE_DEPTH = bsvi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  bsvi_pkg::request_t request,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output bsvi_pkg::result_t  result
);
  import bsvi_pkg::*;

  logic [1:0]       pack_type;
  logic [VAL_W-1:0] sensor_gain;

  logic   push;
  job_t   push_job;
  logic   pop;
  job_t   pop_job;
  qstat_t qstat;

  // Configuration writes are accepted in every cycle; the user, not the block,
  // must issue them only while idle, so no item in flight sees a table change.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_type   <= PACK_RESET;
      sensor_gain <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PACK: pack_type   <= cfg_data[1:0];
        CFG_GAIN: sensor_gain <= cfg_data;
      endcase
    end
  end

  // The front end scales the voltage, picks the table segment or the clamp,
  // and hands a job of the form base + dy * off / dx to the queue.
  bsvi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .pack_type  (pack_type),
    .sensor_gain(sensor_gain),
    .qstat      (qstat),
    .push       (push),
    .job        (push_job)
  );

  bsvi_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_job),
    .pop      (pop),
    .pop_data (pop_job),
    .qstat    (qstat)
  );

  // The back end multiplies, divides and adds the base, one job per cycle.
  bsvi_back u_back (
    .clk   (clk),
    .rst   (rst),
    .avail (~qstat.empty),
    .job   (pop_job),
    .pop   (pop),
    .done  (done),
    .result(result)
  );

endmodule

@@ design/bsvi_checker.sv @@
`timescale 1ns / 1ps

module bsvi_checker (
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              done,
  input bsvi_pkg::result_t result
);
  import bsvi_pkg::*;

  // Reset empties the pipeline and the queue.
  a_reset_clears: assert property (@(posedge clk) rst |=> (!done && !busy))
    else $error("result strobe or busy seen right after reset");

  a_region_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.region == REGION_INTERP || result.region == REGION_TOP ||
              result.region == REGION_BOTTOM))
    else $error("result carries an undefined region code");

  // No charge exceeds 100 percent and no table voltage exceeds it either.
  a_answer_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.answer <= SOC_TAB[0]))
    else $error("answer beyond the largest table value");

  a_top_clamp: assert property (@(posedge clk) disable iff (rst)
    (done && result.region == REGION_TOP) |-> (result.answer >= VOLT_TAB[0][0]))
    else $error("top clamp gave an answer below every top point");

  a_bottom_clamp: assert property (@(posedge clk) disable iff (rst)
    (done && result.region == REGION_BOTTOM) |->
      (result.answer == SOC_FLOOR || result.answer == VOLT_TAB[0][NPTS-1] ||
       result.answer == VOLT_TAB[1][NPTS-1] || result.answer == VOLT_TAB[2][NPTS-1] ||
       result.answer == VOLT_TAB[3][NPTS-1]))
    else $error("bottom clamp gave an answer that is no bottom value");

endmodule

bind battery_soc_voltage_interpolator bsvi_checker u_bsvi_checker (.*);

@@ tb/sv/battery_soc_voltage_interpolator_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the state-of-charge / voltage interpolator.
// A directed table runs first with the reset configuration. Random phases
// follow, and each one rewrites both registers while the block is idle.
module battery_soc_voltage_interpolator_tb;
  import bsvi_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 9;
  // The bench waits this long after the last result to be sure that nothing is
  // still in flight.
  localparam int SETTLE_CYCLES   = 20;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int PROBES          = 21;

  localparam logic [15:0] CHARGE_FULL   = 16'd10000;
  localparam logic [15:0] CHARGE_FLOOR  = 16'd500;
  localparam int          CHARGE_LOWEST = 1000;
  localparam logic [15:0] UNITY_GAIN    = 16'd32768;

  // One row of the directed table. When typed is set, the expected answer and
  // region are written into the row. Otherwise the predictor supplies them.
  typedef struct packed {
    logic        action;
    logic [15:0] value;
    logic        typed;
    logic [15:0] answer;
    logic [1:0]  region;
  } probe_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     cfg_valid;
  logic     cfg_ready;
  logic     cfg_index;
  logic [15:0] cfg_data;
  logic     done;
  result_t  result;

  // The bench keeps its own copy of the voltage curve of each pack type,
  // highest point first, and of the charge points that go with it.
  int pack_volts [4][11] = '{
    '{1460, 1400, 1360, 1340, 1325, 1320, 1300, 1280, 1260, 1240, 1200},
    '{2920, 2800, 2720, 2680, 2650, 2640, 2600, 2560, 2520, 2480, 2400},
    '{4380, 4200, 4080, 4020, 3975, 3960, 3900, 3840, 3780, 3720, 3600},
    '{5840, 5600, 5440, 5360, 5300, 5280, 5200, 5120, 5040, 4960, 4800}
  };
  int charge_pts [11] = '{
    10000, 9500, 9000, 8000, 7000, 6000, 5000, 4000, 3000, 2000, 1000
  };

  // The bench's copy of the two configuration registers. It follows every
  // register transfer.
  logic [1:0]  model_pack;
  logic [15:0] model_gain;

  result_t expected_results[$];
  result_t oldest;
  int      failures;
  int      idle_pct;
  int      cycle_count;

  // Directed table, run with the reset configuration (12 V pack, unity gain).
  // It covers both ends of each field, both clamps, the exact bottom charge
  // point and several exact table points.
  probe_t probes [PROBES] = '{
    '{ACT_V2S, 16'd0,     1'b1, 16'd500,   REGION_BOTTOM},
    '{ACT_V2S, 16'd65535, 1'b1, 16'd10000, REGION_TOP},
    '{ACT_V2S, 16'd1460,  1'b1, 16'd10000, REGION_TOP},
    '{ACT_V2S, 16'd1459,  1'b0, 16'd0,     REGION_INTERP},
    '{ACT_V2S, 16'd1200,  1'b1, 16'd500,   REGION_BOTTOM},
    '{ACT_V2S, 16'd1201,  1'b0, 16'd0,     REGION_INTERP},
    '{ACT_V2S, 16'd1325,  1'b1, 16'd7000,  REGION_INTERP},
    '{ACT_V2S, 16'd1320,  1'b1, 16'd6000,  REGION_INTERP},
    '{ACT_V2S, 16'd1333,  1'b0, 16'd0,     REGION_INTERP},
    '{ACT_V2S, 16'h8000,  1'b1, 16'd10000, REGION_TOP},
    '{ACT_V2S, 16'h5555,  1'b1, 16'd10000, REGION_TOP},
    '{ACT_S2V, 16'd0,     1'b1, 16'd1200,  REGION_BOTTOM},
    '{ACT_S2V, 16'd999,   1'b1, 16'd1200,  REGION_BOTTOM},
    '{ACT_S2V, 16'd1000,  1'b1, 16'd1200,  REGION_INTERP},
    '{ACT_S2V, 16'd10000, 1'b1, 16'd1460,  REGION_TOP},
    '{ACT_S2V, 16'd65535, 1'b1, 16'd1460,  REGION_TOP},
    '{ACT_S2V, 16'd9999,  1'b0, 16'd0,     REGION_INTERP},
    '{ACT_S2V, 16'd5000,  1'b1, 16'd1300,  REGION_INTERP},
    '{ACT_S2V, 16'd7777,  1'b0, 16'd0,     REGION_INTERP},
    '{ACT_S2V, 16'haaaa,  1'b1, 16'd1460,  REGION_TOP},
    '{ACT_S2V, 16'd1001,  1'b0, 16'd0,     REGION_INTERP}
  };

  battery_soc_voltage_interpolator DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Computes the answer the block should give under the current copy of the
  // configuration. A voltage is first scaled by the Q1.15 gain, truncated and
  // saturated to 16 bits. Then the segment is searched from the top of the
  // table down, and the quotient of the interpolation is truncated.
  function automatic result_t convert_reading(request_t req);
    result_t     r;
    logic [31:0] scaled;
    int          x;
    int          k;
    logic        found;
    r.answer = '0;
    r.region = REGION_INTERP;
    found    = 1'b0;
    if (req.action == ACT_V2S) begin
      scaled = (32'(req.value) * 32'(model_gain)) >> 15;
      x = (scaled > 32'hFFFF) ? 32'hFFFF : int'(scaled);
      if (x >= pack_volts[model_pack][0]) begin
        r.answer = CHARGE_FULL;
        r.region = REGION_TOP;
      end else if (x <= pack_volts[model_pack][10]) begin
        r.answer = CHARGE_FLOOR;
        r.region = REGION_BOTTOM;
      end else begin
        for (k = 0; k < 10; k++) begin
          if (!found && x <= pack_volts[model_pack][k] &&
              x >= pack_volts[model_pack][k+1]) begin
            r.answer = 16'(charge_pts[k+1] + (charge_pts[k] - charge_pts[k+1]) *
                           (x - pack_volts[model_pack][k+1]) /
                           (pack_volts[model_pack][k] - pack_volts[model_pack][k+1]));
            found = 1'b1;
          end
        end
      end
    end else begin
      x = int'(req.value);
      if (x >= int'(CHARGE_FULL)) begin
        r.answer = 16'(pack_volts[model_pack][0]);
        r.region = REGION_TOP;
      end else if (x < CHARGE_LOWEST) begin
        r.answer = 16'(pack_volts[model_pack][10]);
        r.region = REGION_BOTTOM;
      end else begin
        for (k = 0; k < 10; k++) begin
          if (!found && x <= charge_pts[k] && x >= charge_pts[k+1]) begin
            r.answer = 16'(pack_volts[model_pack][k+1] +
                           (pack_volts[model_pack][k] - pack_volts[model_pack][k+1]) *
                           (x - charge_pts[k+1]) / (charge_pts[k] - charge_pts[k+1]));
            found = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // Most random voltages are aimed at the interpolated span of the chosen
  // pack after calibration, with some placed next to table points. Most random
  // charges fall between 0 and a little over 100%. The rest of the requests
  // carry fully random values so that every bit of the field toggles.
  function automatic request_t random_request(int pack, int gain);
    request_t req;
    int       pick;
    int       target;
    longint   raw;
    pick = $urandom_range(0, 99);
    req.action = ($urandom_range(0, 1) != 0) ? ACT_S2V : ACT_V2S;
    if (pick < 12) begin
      req.value = 16'($urandom);
    end else if (req.action == ACT_V2S) begin
      if (pick < 25) begin
        target = pack_volts[pack][$urandom_range(0, 10)] + int'($urandom_range(0, 2)) - 1;
      end else begin
        target = $urandom_range(pack_volts[pack][10] - 40, pack_volts[pack][0] + 40);
      end
      if (gain == 0) begin
        raw = target;
      end else begin
        raw = (longint'(target) * 32768 + gain - 1) / gain;
      end
      req.value = (raw > 65535) ? 16'hFFFF : 16'(raw);
    end else begin
      if (pick < 25) begin
        req.value = 16'(charge_pts[$urandom_range(0, 10)] + int'($urandom_range(0, 2)) - 1);
      end else begin
        req.value = 16'($urandom_range(0, 10400));
      end
    end
    return req;
  endfunction

  // Presents one request and holds it until it transfers. When the transfer
  // happens, the expected result is queued: the typed value for a directed row
  // that carries one, otherwise the predictor's answer. The sender then idles
  // for a random number of cycles, set by idle_pct.
  task automatic send_request(input request_t req, input logic typed, input result_t known);
    @(negedge clk);
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    expected_results.push_back(typed ? known : convert_reading(req));
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Stops sending and waits until every expected result has arrived. Then it
  // lets the pipeline go quiet before anything else happens.
  task automatic wait_for_answers();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register over the configuration channel. The predictor's copy
  // is updated at the edge where the transfer happens.
  task automatic write_register(input logic index, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (index == CFG_PACK) begin
      model_pack = data[1:0];
    end else begin
      model_gain = data;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result checker. The receiver cannot hold results off, so every strobe is
  // a transfer. Each one is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, answer %0d region %0d",
                 $time, result.answer, result.region);
        failures = failures + 1;
      end else begin
        oldest = expected_results.pop_front();
        if (result.answer !== oldest.answer) begin
          $display("%0t: answer mismatch, expected %0d actual %0d",
                   $time, oldest.answer, result.answer);
          failures = failures + 1;
        end
        if (result.region !== oldest.region) begin
          $display("%0t: region mismatch, expected %0d actual %0d",
                   $time, oldest.region, result.region);
          failures = failures + 1;
        end
      end
    end
  end

  // Watchdog. A hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("battery_soc_voltage_interpolator verification failed");
      $finish;
    end
  end

  initial begin
    int      phase_pack [PHASES];
    int      phase_gain [PHASES];
    int      idle_plan [3];
    int      p;
    int      n;
    result_t known;
    rst         = 1'b1;
    start       = 1'b0;
    request     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_PACK;
    cfg_data    = '0;
    model_pack  = 2'd0;
    model_gain  = UNITY_GAIN;
    failures    = 0;
    cycle_count = 0;
    // The sender idles about a third of the time, then nearly two thirds,
    // then never.
    idle_plan   = '{34, 62, 0};
    idle_pct    = idle_plan[0];

    // The pack types include both ends of the range. The gains include zero,
    // full scale, half and unity, and also random settings.
    phase_pack = '{0, 3, 1, 2, 1, 0, 3, 2, 0};
    phase_gain = '{32768, 65535, 0, 0, 0, 16384, 0, 0, 32768};
    phase_gain[3] = $urandom_range(26000, 40000);
    phase_gain[4] = $urandom_range(0, 65535);
    phase_gain[6] = $urandom_range(30000, 36000);
    phase_gain[7] = $urandom_range(20000, 50000);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (n = 0; n < PROBES; n++) begin
      known.answer = probes[n].answer;
      known.region = probes[n].region;
      send_request('{probes[n].action, probes[n].value}, probes[n].typed, known);
    end

    // Each phase drains the block, which exercises a sender pause until every
    // result is in. Then it rewrites both registers and runs random traffic.
    for (p = 0; p < PHASES; p++) begin
      idle_pct = idle_plan[p / 3];
      wait_for_answers();
      write_register(CFG_PACK, 16'(phase_pack[p]));
      write_register(CFG_GAIN, 16'(phase_gain[p]));
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_request(random_request(phase_pack[p], phase_gain[p]), 1'b0, '0);
      end
    end

    wait_for_answers();
    if (failures == 0) begin
      $display("battery_soc_voltage_interpolator verification clean");
    end else begin
      $display("battery_soc_voltage_interpolator verification failed");
    end
    $finish;
  end

endmodule
